### hw/rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and widths for the quaternion vector rotator
// Word formats of both channels and the internal widths of the exact datapath.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // operand format
  localparam int DATA_WIDTH     = 32;
  localparam int QUAT_FRAC_BITS = 30;

  // first product q*v and the sums of three of them
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int T_W    = PROD_W + 2;

  // second product is split into a low and a high partial product
  localparam int LO_W  = T_W / 2;
  localparam int HI_W  = T_W - LO_W;
  localparam int PLO_W = DATA_WIDTH + LO_W + 1;
  localparam int PHI_W = DATA_WIDTH + HI_W;
  localparam int P2_W  = DATA_WIDTH + T_W;

  // final sums, rounding shift and the rounded value
  localparam int R_W       = P2_W + 2;
  localparam int RND_SHIFT = 2 * QUAT_FRAC_BITS;
  localparam int Y_W       = R_W - RND_SHIFT;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [T_W-1:0]        tval_t;
  typedef logic signed [PLO_W-1:0]      plo_t;
  typedef logic signed [PHI_W-1:0]      phi_t;
  typedef logic signed [P2_W-1:0]       p2_t;
  typedef logic signed [R_W-1:0]        rsum_t;
  typedef logic signed [Y_W-1:0]        yval_t;

  // input word: direction bit, quaternion, vector
  typedef struct packed {
    logic  op;
    data_t q_w;
    data_t q_x;
    data_t q_y;
    data_t q_z;
    data_t v_x;
    data_t v_y;
    data_t v_z;
  } in_word_t;

  // result word: rotated vector and saturation flag
  typedef struct packed {
    data_t r_x;
    data_t r_y;
    data_t r_z;
    logic  overflow;
  } out_word_t;

endpackage

### hw/rtl/quaternion_vector_rotate_top.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top: pipelined rotation of a vector by a quaternion
// Forms q' (0,v) conj(q') exactly, rounds to nearest and saturates.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_stall/in_data carry one word: op, quaternion (Q2.30) and
//   vector (Q16.16). op = 1 rotates by the conjugate of q (inverse rotation).
//   out_valid/out_stall/out_data return one word per input word, in order:
//   the rotated vector (Q16.16) and an overflow flag set if any component
//   was saturated. q is not normalized, so the result scales by |q|^2.
// Pipeline and throughput
//   an accepted word goes through stages 1 to 8 and the output register.
//   One word per cycle is accepted unless out_stall holds a waiting result;
//   the eight multiply and add register stages all advance together.
// Reset
//   rst_n clears the stage valid bits only; the pipeline comes up empty.
// Stall
//   while out_stall holds a waiting result, the whole pipeline freezes and
//   in_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qvr_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qvr_pkg::out_word_t  out_data
);

  localparam int NPROD = 12;
  localparam int NSTG  = 8;

  localparam qvr_pkg::rsum_t RND_HALF = qvr_pkg::rsum_t'(1) <<< (qvr_pkg::RND_SHIFT - 1);
  localparam qvr_pkg::data_t SAT_MAX  = {1'b0, {(qvr_pkg::DATA_WIDTH-1){1'b1}}};
  localparam qvr_pkg::data_t SAT_MIN  = {1'b1, {(qvr_pkg::DATA_WIDTH-1){1'b0}}};

  // low partial product: signed operand times the unsigned low half of t
  function automatic qvr_pkg::plo_t mul_lo(input qvr_pkg::data_t a, input qvr_pkg::tval_t b);
    logic signed [qvr_pkg::LO_W:0] bl;
    bl = {1'b0, b[qvr_pkg::LO_W-1:0]};
    return qvr_pkg::plo_t'(a) * qvr_pkg::plo_t'(bl);
  endfunction

  // high partial product: signed operand times the signed high half of t
  function automatic qvr_pkg::phi_t mul_hi(input qvr_pkg::data_t a, input qvr_pkg::tval_t b);
    logic signed [qvr_pkg::HI_W-1:0] bh;
    bh = b[qvr_pkg::T_W-1:qvr_pkg::LO_W];
    return qvr_pkg::phi_t'(a) * qvr_pkg::phi_t'(bh);
  endfunction

  logic adv;
  logic [NSTG:1] vld_r;
  logic          out_valid_r;

  // stage 1: registered input word
  logic           op1_r;
  qvr_pkg::data_t qw1_r, qx1_r, qy1_r, qz1_r;
  qvr_pkg::data_t vx1_r, vy1_r, vz1_r;

  // stage 2: first products
  logic           op2_r;
  qvr_pkg::data_t qw2_r, qx2_r, qy2_r, qz2_r;
  qvr_pkg::prod_t pxx_r, pyy_r, pzz_r, pxw_r, pyw_r, pzw_r;
  qvr_pkg::prod_t pyz_r, pzy_r, pxz_r, pzx_r, pxy_r, pyx_r;

  // stage 3: dot product and cross terms
  logic           op3_r;
  qvr_pkg::data_t qw3_r, qx3_r, qy3_r, qz3_r;
  qvr_pkg::tval_t u0_3_r, ca3_r, cb3_r, cc3_r;
  qvr_pkg::prod_t pxw3_r, pyw3_r, pzw3_r;

  // stage 4: t = (0,v) conj(q'), cross terms signed by the direction sign
  logic           op4_r;
  qvr_pkg::data_t qw4_r, qx4_r, qy4_r, qz4_r;
  qvr_pkg::tval_t u0_4_r, t1_4_r, t2_4_r, t3_4_r;

  // stage 5: split second products
  logic           op5_r;
  qvr_pkg::plo_t  plo5_r [NPROD];
  qvr_pkg::phi_t  phi5_r [NPROD];
  qvr_pkg::data_t ma [NPROD];
  qvr_pkg::tval_t mb [NPROD];

  // stage 6: whole second products
  logic           op6_r;
  qvr_pkg::p2_t   prd6_r [NPROD];

  // stage 7: pair sums and differences
  logic           op7_r;
  qvr_pkg::rsum_t e7_r [3];
  qvr_pkg::rsum_t d7_r [3];

  // stage 8: vector part of q' t
  qvr_pkg::rsum_t r8_r [3];

  // output register
  qvr_pkg::out_word_t out_r;
  qvr_pkg::out_word_t out_nxt;

  // pipeline moves unless a finished word is held by the receiver
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-1:1], in_valid};
      out_valid_r <= vld_r[NSTG];
    end
  end

  // second product operand selection
  //   r1 = w t1 + x u0 + s (y t3 - z t2)
  //   r2 = w t2 + y u0 + s (z t1 - x t3)
  //   r3 = w t3 + z u0 + s (x t2 - y t1)
  always_comb begin
    ma[0]  = qw4_r;  mb[0]  = t1_4_r;
    ma[1]  = qx4_r;  mb[1]  = u0_4_r;
    ma[2]  = qy4_r;  mb[2]  = t3_4_r;
    ma[3]  = qz4_r;  mb[3]  = t2_4_r;
    ma[4]  = qw4_r;  mb[4]  = t2_4_r;
    ma[5]  = qy4_r;  mb[5]  = u0_4_r;
    ma[6]  = qz4_r;  mb[6]  = t1_4_r;
    ma[7]  = qx4_r;  mb[7]  = t3_4_r;
    ma[8]  = qw4_r;  mb[8]  = t3_4_r;
    ma[9]  = qz4_r;  mb[9]  = u0_4_r;
    ma[10] = qx4_r;  mb[10] = t2_4_r;
    ma[11] = qy4_r;  mb[11] = t1_4_r;
  end

  // round to nearest (half up), then saturate each component
  always_comb begin
    qvr_pkg::rsum_t rnd;
    qvr_pkg::yval_t y;
    qvr_pkg::data_t val [3];
    logic           ovf [3];
    for (int k = 0; k < 3; k++) begin
      rnd = r8_r[k] + RND_HALF;
      y   = rnd[qvr_pkg::R_W-1:qvr_pkg::RND_SHIFT];
      if (y[qvr_pkg::Y_W-1:qvr_pkg::DATA_WIDTH-1] == '0 ||
          y[qvr_pkg::Y_W-1:qvr_pkg::DATA_WIDTH-1] == '1) begin
        val[k] = y[qvr_pkg::DATA_WIDTH-1:0];
        ovf[k] = 1'b0;
      end else begin
        val[k] = y[qvr_pkg::Y_W-1] ? SAT_MIN : SAT_MAX;
        ovf[k] = 1'b1;
      end
    end
    out_nxt.r_x      = val[0];
    out_nxt.r_y      = val[1];
    out_nxt.r_z      = val[2];
    out_nxt.overflow = ovf[0] | ovf[1] | ovf[2];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      op1_r <= in_data.op;
      qw1_r <= in_data.q_w;
      qx1_r <= in_data.q_x;
      qy1_r <= in_data.q_y;
      qz1_r <= in_data.q_z;
      vx1_r <= in_data.v_x;
      vy1_r <= in_data.v_y;
      vz1_r <= in_data.v_z;

      // stage 2
      op2_r <= op1_r;
      qw2_r <= qw1_r;
      qx2_r <= qx1_r;
      qy2_r <= qy1_r;
      qz2_r <= qz1_r;
      pxx_r <= qvr_pkg::prod_t'(vx1_r) * qvr_pkg::prod_t'(qx1_r);
      pyy_r <= qvr_pkg::prod_t'(vy1_r) * qvr_pkg::prod_t'(qy1_r);
      pzz_r <= qvr_pkg::prod_t'(vz1_r) * qvr_pkg::prod_t'(qz1_r);
      pxw_r <= qvr_pkg::prod_t'(vx1_r) * qvr_pkg::prod_t'(qw1_r);
      pyw_r <= qvr_pkg::prod_t'(vy1_r) * qvr_pkg::prod_t'(qw1_r);
      pzw_r <= qvr_pkg::prod_t'(vz1_r) * qvr_pkg::prod_t'(qw1_r);
      pyz_r <= qvr_pkg::prod_t'(vy1_r) * qvr_pkg::prod_t'(qz1_r);
      pzy_r <= qvr_pkg::prod_t'(vz1_r) * qvr_pkg::prod_t'(qy1_r);
      pxz_r <= qvr_pkg::prod_t'(vx1_r) * qvr_pkg::prod_t'(qz1_r);
      pzx_r <= qvr_pkg::prod_t'(vz1_r) * qvr_pkg::prod_t'(qx1_r);
      pxy_r <= qvr_pkg::prod_t'(vx1_r) * qvr_pkg::prod_t'(qy1_r);
      pyx_r <= qvr_pkg::prod_t'(vy1_r) * qvr_pkg::prod_t'(qx1_r);

      // stage 3
      op3_r  <= op2_r;
      qw3_r  <= qw2_r;
      qx3_r  <= qx2_r;
      qy3_r  <= qy2_r;
      qz3_r  <= qz2_r;
      u0_3_r <= qvr_pkg::tval_t'(pxx_r) + qvr_pkg::tval_t'(pyy_r) + qvr_pkg::tval_t'(pzz_r);
      ca3_r  <= qvr_pkg::tval_t'(pyz_r) - qvr_pkg::tval_t'(pzy_r);
      cb3_r  <= qvr_pkg::tval_t'(pxz_r) - qvr_pkg::tval_t'(pzx_r);
      cc3_r  <= qvr_pkg::tval_t'(pxy_r) - qvr_pkg::tval_t'(pyx_r);
      pxw3_r <= pxw_r;
      pyw3_r <= pyw_r;
      pzw3_r <= pzw_r;

      // stage 4: sign s is +1 for a forward rotation, -1 for inverse
      op4_r  <= op3_r;
      qw4_r  <= qw3_r;
      qx4_r  <= qx3_r;
      qy4_r  <= qy3_r;
      qz4_r  <= qz3_r;
      u0_4_r <= u0_3_r;
      t1_4_r <= qvr_pkg::tval_t'(pxw3_r) + (op3_r ? ca3_r : -ca3_r);
      t2_4_r <= qvr_pkg::tval_t'(pyw3_r) + (op3_r ? -cb3_r : cb3_r);
      t3_4_r <= qvr_pkg::tval_t'(pzw3_r) + (op3_r ? cc3_r : -cc3_r);

      // stage 5
      op5_r <= op4_r;
      for (int i = 0; i < NPROD; i++) begin
        plo5_r[i] <= mul_lo(ma[i], mb[i]);
        phi5_r[i] <= mul_hi(ma[i], mb[i]);
      end

      // stage 6
      op6_r <= op5_r;
      for (int i = 0; i < NPROD; i++) begin
        prd6_r[i] <= (qvr_pkg::p2_t'(phi5_r[i]) <<< qvr_pkg::LO_W) +
                     qvr_pkg::p2_t'(plo5_r[i]);
      end

      // stage 7
      op7_r <= op6_r;
      for (int k = 0; k < 3; k++) begin
        e7_r[k] <= qvr_pkg::rsum_t'(prd6_r[4*k])   + qvr_pkg::rsum_t'(prd6_r[4*k+1]);
        d7_r[k] <= qvr_pkg::rsum_t'(prd6_r[4*k+2]) - qvr_pkg::rsum_t'(prd6_r[4*k+3]);
      end

      // stage 8
      for (int k = 0; k < 3; k++) begin
        r8_r[k] <= e7_r[k] + (op7_r ? -d7_r[k] : d7_r[k]);
      end

      // output word
      out_r <= out_nxt;
    end
  end

endmodule
